// File: src/srlm_pkg.sv
// Shared types and constants for the stereo RMS level meter.
package srlm_pkg;

    // Sizes of the accumulators and the frame limit.
    localparam int MAX_FRAMES = 4096;
    localparam int FRAMES_W   = $clog2(MAX_FRAMES + 1);
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 64;
    localparam int LEVEL_W    = 17;

    // Level computation datapath widths.
    localparam int ACC_W      = 73;   // signed n*Q - S*S
    localparam int RAD_W      = 120;  // radicand after the scale shift
    localparam int ROOT_W     = 60;   // integer square root of the radicand
    localparam int REM_W      = 61;   // square root and divide remainder
    localparam int K_W        = 44;   // frames times full scale
    localparam int MAG_W      = 36;   // magnitude of a channel sum
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = ROOT_W;

    // Full-scale values per format.
    localparam logic [30:0] FS_U8  = 31'd128;
    localparam logic [30:0] FS_S16 = 31'd32767;
    localparam logic [30:0] FS_S32 = 31'd2147483647;

    // Sample formats.
    localparam logic [1:0] FMT_U8   = 2'd0;
    localparam logic [1:0] FMT_S16  = 2'd1;
    localparam logic [1:0] FMT_S32  = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] CFG_SAMPLE_FORMAT = 8'd0;
    localparam logic [7:0] CFG_CHANNEL_COUNT = 8'd1;
    localparam logic [7:0] CFG_BIG_ENDIAN    = 8'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_LEFT,
        S_ACC_LEFT,
        S_ACC_RIGHT,
        S_FIN_START,
        S_NQ_LO,
        S_NQ_HI,
        S_SS_LL,
        S_SS_LH,
        S_SS_HH,
        S_SS_END,
        S_SCALE,
        S_SQRT,
        S_DIV_CHK,
        S_DIV,
        S_CH_DONE,
        S_OUT
    } t_state;

endpackage

// File: src/stereo_rms_level_meter.sv
// Stereo RMS level meter with mean removal: accumulators and the shared level sequencer.
// A sample that does not close a frame is taken with no stall; one that closes a
// frame holds o_stall while one shared 32x32 multiplier squares left then right
// (the right square is used in stereo only). The final sample adds, per channel, six
// multiplier passes, a 60-step bit-serial square root and a 17-step divide on one
// shared subtractor. Reset (i_rst_n low, synchronous) clears all accumulators and
// restores the registers to 16-bit signed, two channels, little endian.
module stereo_rms_level_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_word,
    input  logic        i_last,
    // level channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_level_left,
    output logic [16:0] o_level_right,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    srlm_pkg::t_state r_state, n_state;

    // configuration registers
    logic [1:0] r_fmt;
    logic [4:0] r_chan_cnt;
    logic       r_big_endian;

    // per-buffer accumulators
    logic signed [srlm_pkg::SUM_W-1:0]    r_sum_l, r_sum_r;
    logic        [srlm_pkg::SQ_W-1:0]     r_sq_l, r_sq_r;
    logic        [srlm_pkg::FRAMES_W-1:0] r_frames;
    logic        [3:0]                    r_pos;
    logic signed [srlm_pkg::SAMPLE_W-1:0] r_held_l, r_held_r;

    // captured at accept
    logic r_last;
    logic r_stereo;

    // level sequencer
    logic        [63:0]                 r_prod;
    logic signed [srlm_pkg::ACC_W-1:0]  r_acc;
    logic        [srlm_pkg::K_W-1:0]    r_k;
    logic        [srlm_pkg::RAD_W-1:0]  r_rad;
    logic        [srlm_pkg::ROOT_W-1:0] r_root;
    logic        [srlm_pkg::REM_W-1:0]  r_rem;
    logic        [srlm_pkg::LEVEL_W-1:0] r_quot;
    logic        [srlm_pkg::CNT_W-1:0]  r_cnt;
    logic                               r_ch;
    logic        [srlm_pkg::LEVEL_W-1:0] r_lvl_l, r_lvl_r;

    // output register
    logic                                r_out_valid;
    logic        [srlm_pkg::LEVEL_W-1:0] r_out_l, r_out_r;

    logic                               w_in_acc;
    logic                               w_out_free;
    logic [4:0]                         w_cc_eff;
    logic signed [srlm_pkg::SAMPLE_W-1:0] w_dec;
    logic [15:0]                        w_half;
    logic                               w_frame_end;
    logic                               w_accumulate;
    logic [31:0]                        w_mul_a, w_mul_b;
    logic [63:0]                        w_sub_a, w_sub_b;
    logic [64:0]                        w_sub_diff;
    logic                               w_ge;
    logic [30:0]                        w_fs;
    logic                               w_sh48;
    logic signed [srlm_pkg::SUM_W-1:0]  w_sum_sel;
    logic [srlm_pkg::SUM_W-1:0]         w_sum_neg;
    logic [srlm_pkg::MAG_W-1:0]         w_mag;
    logic [srlm_pkg::SQ_W-1:0]          w_sq_sel;
    logic [srlm_pkg::SAMPLE_W-1:0]      w_abs_l, w_abs_r;

    assign o_stall     = (r_state != srlm_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_level_left  = r_out_l;
    assign o_level_right = r_out_r;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Effective channel count: zero acts as one, anything above sixteen as sixteen.
    always_comb begin
        if (r_chan_cnt == 5'd0) begin
            w_cc_eff = 5'd1;
        end else if (r_chan_cnt > 5'd16) begin
            w_cc_eff = 5'd16;
        end else begin
            w_cc_eff = r_chan_cnt;
        end
    end

    // Decode the raw word with the format in force now.
    assign w_half = r_big_endian ? {i_sample_word[7:0], i_sample_word[15:8]}
                                 : i_sample_word[15:0];
    always_comb begin
        unique case (r_fmt)
            srlm_pkg::FMT_U8:  w_dec = {16'd0, i_sample_word[7:0]};
            srlm_pkg::FMT_S16: w_dec = {{8{w_half[15]}}, w_half};
            srlm_pkg::FMT_S32: w_dec = i_sample_word[31:8];
            default:           w_dec = '0;
        endcase
    end

    // A frame closes once the position reaches or passes the count.
    assign w_frame_end  = ({1'b0, r_pos} + 5'd1) >= w_cc_eff;
    assign w_accumulate = w_frame_end &&
        (r_frames < srlm_pkg::FRAMES_W'(srlm_pkg::MAX_FRAMES));

    // Full scale and scale shift follow the format in force while the level is computed.
    always_comb begin
        unique case (r_fmt)
            srlm_pkg::FMT_U8:  w_fs = srlm_pkg::FS_U8;
            srlm_pkg::FMT_S16: w_fs = srlm_pkg::FS_S16;
            srlm_pkg::FMT_S32: w_fs = srlm_pkg::FS_S32;
            default:           w_fs = '0;
        endcase
    end
    assign w_sh48 = (r_fmt == srlm_pkg::FMT_S32);

    // Operands of the channel under computation.
    assign w_sum_sel = r_ch ? r_sum_r : r_sum_l;
    assign w_sq_sel  = r_ch ? r_sq_r : r_sq_l;
    assign w_sum_neg = ~w_sum_sel + 1'b1;
    assign w_mag     = w_sum_sel[srlm_pkg::SUM_W-1] ? w_sum_neg[srlm_pkg::MAG_W-1:0]
                                                    : w_sum_sel[srlm_pkg::MAG_W-1:0];
    assign w_abs_l   = r_held_l[srlm_pkg::SAMPLE_W-1] ? (~r_held_l + 1'b1) : r_held_l;
    assign w_abs_r   = r_held_r[srlm_pkg::SAMPLE_W-1] ? (~r_held_r + 1'b1) : r_held_r;

    // Shared multiplier operand select.
    always_comb begin
        unique case (r_state)
            srlm_pkg::S_SQ_LEFT: begin
                w_mul_a = {8'd0, w_abs_l};
                w_mul_b = {8'd0, w_abs_l};
            end
            srlm_pkg::S_ACC_LEFT: begin
                w_mul_a = {8'd0, w_abs_r};
                w_mul_b = {8'd0, w_abs_r};
            end
            srlm_pkg::S_NQ_LO: begin
                w_mul_a = {19'd0, r_frames};
                w_mul_b = w_sq_sel[31:0];
            end
            srlm_pkg::S_NQ_HI: begin
                w_mul_a = {19'd0, r_frames};
                w_mul_b = w_sq_sel[63:32];
            end
            srlm_pkg::S_SS_LL: begin
                w_mul_a = w_mag[31:0];
                w_mul_b = w_mag[31:0];
            end
            srlm_pkg::S_SS_LH: begin
                w_mul_a = w_mag[31:0];
                w_mul_b = {28'd0, w_mag[35:32]};
            end
            srlm_pkg::S_SS_HH: begin
                w_mul_a = {28'd0, w_mag[35:32]};
                w_mul_b = {28'd0, w_mag[35:32]};
            end
            srlm_pkg::S_SS_END: begin
                w_mul_a = {19'd0, r_frames};
                w_mul_b = {1'b0, w_fs};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Shared subtractor: square root trial, overflow check and divide trial.
    always_comb begin
        unique case (r_state)
            srlm_pkg::S_SQRT: begin
                w_sub_a = {1'b0, r_rem, r_rad[srlm_pkg::RAD_W-1 -: 2]};
                w_sub_b = {2'b00, r_root, 2'b01};
            end
            srlm_pkg::S_DIV_CHK: begin
                w_sub_a = {21'd0, r_root[srlm_pkg::ROOT_W-1:srlm_pkg::LEVEL_W]};
                w_sub_b = {20'd0, r_k};
            end
            srlm_pkg::S_DIV: begin
                w_sub_a = {19'd0, r_rem[srlm_pkg::K_W-1:0], r_quot[srlm_pkg::LEVEL_W-1]};
                w_sub_b = {20'd0, r_k};
            end
            default: begin
                w_sub_a = '0;
                w_sub_b = '0;
            end
        endcase
    end
    assign w_sub_diff = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_ge       = !w_sub_diff[64];

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srlm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srlm_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_accumulate) begin
                        n_state = srlm_pkg::S_SQ_LEFT;
                    end else if (i_last) begin
                        n_state = srlm_pkg::S_FIN_START;
                    end
                end
            end
            srlm_pkg::S_SQ_LEFT: n_state = srlm_pkg::S_ACC_LEFT;
            srlm_pkg::S_ACC_LEFT: begin
                if (r_stereo) begin
                    n_state = srlm_pkg::S_ACC_RIGHT;
                end else if (r_last) begin
                    n_state = srlm_pkg::S_FIN_START;
                end else begin
                    n_state = srlm_pkg::S_IDLE;
                end
            end
            srlm_pkg::S_ACC_RIGHT: begin
                n_state = r_last ? srlm_pkg::S_FIN_START : srlm_pkg::S_IDLE;
            end
            srlm_pkg::S_FIN_START: begin
                if (w_fs == '0 || r_frames == '0) begin
                    n_state = srlm_pkg::S_OUT;
                end else begin
                    n_state = srlm_pkg::S_NQ_LO;
                end
            end
            srlm_pkg::S_NQ_LO:  n_state = srlm_pkg::S_NQ_HI;
            srlm_pkg::S_NQ_HI:  n_state = srlm_pkg::S_SS_LL;
            srlm_pkg::S_SS_LL:  n_state = srlm_pkg::S_SS_LH;
            srlm_pkg::S_SS_LH:  n_state = srlm_pkg::S_SS_HH;
            srlm_pkg::S_SS_HH:  n_state = srlm_pkg::S_SS_END;
            srlm_pkg::S_SS_END: n_state = srlm_pkg::S_SCALE;
            srlm_pkg::S_SCALE: begin
                n_state = r_acc[srlm_pkg::ACC_W-1] ? srlm_pkg::S_CH_DONE : srlm_pkg::S_SQRT;
            end
            srlm_pkg::S_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = srlm_pkg::S_DIV_CHK;
                end
            end
            srlm_pkg::S_DIV_CHK: begin
                n_state = w_ge ? srlm_pkg::S_CH_DONE : srlm_pkg::S_DIV;
            end
            srlm_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = srlm_pkg::S_CH_DONE;
                end
            end
            srlm_pkg::S_CH_DONE: begin
                n_state = (!r_ch && r_stereo) ? srlm_pkg::S_NQ_LO : srlm_pkg::S_OUT;
            end
            srlm_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = srlm_pkg::S_IDLE;
                end
            end
            default: n_state = srlm_pkg::S_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= srlm_pkg::FMT_S16;
            r_chan_cnt   <= 5'd2;
            r_big_endian <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                srlm_pkg::CFG_SAMPLE_FORMAT: r_fmt        <= i_cfg_data[1:0];
                srlm_pkg::CFG_CHANNEL_COUNT: r_chan_cnt   <= i_cfg_data[4:0];
                srlm_pkg::CFG_BIG_ENDIAN:    r_big_endian <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accumulators: collect held samples, add squares from the multiplier, clear on output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_l  <= '0;
            r_sum_r  <= '0;
            r_sq_l   <= '0;
            r_sq_r   <= '0;
            r_frames <= '0;
            r_pos    <= '0;
            r_held_l <= '0;
            r_held_r <= '0;
            r_last   <= 1'b0;
            r_stereo <= 1'b0;
        end else begin
            unique case (r_state)
                srlm_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_pos == 4'd0) begin
                            r_held_l <= w_dec;
                        end else if (r_pos == 4'd1) begin
                            r_held_r <= w_dec;
                        end
                        r_pos    <= w_frame_end ? 4'd0 : r_pos + 4'd1;
                        r_last   <= i_last;
                        r_stereo <= (w_cc_eff > 5'd1);
                    end
                end
                srlm_pkg::S_ACC_LEFT: begin
                    r_sq_l  <= r_sq_l + r_prod;
                    r_sum_l <= r_sum_l + {{(srlm_pkg::SUM_W-srlm_pkg::SAMPLE_W)
                                           {r_held_l[srlm_pkg::SAMPLE_W-1]}}, r_held_l};
                    if (!r_stereo) begin
                        r_frames <= r_frames + 1'b1;
                    end
                end
                srlm_pkg::S_ACC_RIGHT: begin
                    r_sq_r   <= r_sq_r + r_prod;
                    r_sum_r  <= r_sum_r + {{(srlm_pkg::SUM_W-srlm_pkg::SAMPLE_W)
                                            {r_held_r[srlm_pkg::SAMPLE_W-1]}}, r_held_r};
                    r_frames <= r_frames + 1'b1;
                end
                srlm_pkg::S_OUT: begin
                    if (w_out_free) begin
                        r_sum_l  <= '0;
                        r_sum_r  <= '0;
                        r_sq_l   <= '0;
                        r_sq_r   <= '0;
                        r_frames <= '0;
                        r_pos    <= '0;
                        r_held_l <= '0;
                        r_held_r <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Level sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= 1'b0;
            r_cnt   <= '0;
            r_lvl_l <= '0;
            r_lvl_r <= '0;
        end else begin
            unique case (r_state)
                srlm_pkg::S_FIN_START: begin
                    r_ch    <= 1'b0;
                    r_lvl_l <= '0;
                    r_lvl_r <= '0;
                end
                // n*Q built from two partial products, then S*S from three
                srlm_pkg::S_NQ_HI: r_acc <= {9'd0, r_prod};
                srlm_pkg::S_SS_LL: r_acc <= r_acc + {r_prod[40:0], 32'd0};
                srlm_pkg::S_SS_LH: r_acc <= r_acc - {9'd0, r_prod};
                srlm_pkg::S_SS_HH: r_acc <= r_acc - {r_prod[39:0], 33'd0};
                srlm_pkg::S_SS_END: r_acc <= r_acc - {r_prod[8:0], 64'd0};
                srlm_pkg::S_SCALE: begin
                    r_k    <= r_prod[srlm_pkg::K_W-1:0];
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= srlm_pkg::CNT_W'(srlm_pkg::SQRT_STEPS - 1);
                    r_quot <= '0;
                    if (w_sh48) begin
                        r_rad <= {r_acc[71:0], 48'd0};
                    end else begin
                        r_rad <= {16'd0, r_acc[71:0], 32'd0};
                    end
                end
                // one root bit per cycle, two radicand bits shifted in
                srlm_pkg::S_SQRT: begin
                    r_rad <= {r_rad[srlm_pkg::RAD_W-3:0], 2'b00};
                    r_cnt <= r_cnt - 1'b1;
                    if (w_ge) begin
                        r_rem  <= w_sub_diff[srlm_pkg::REM_W-1:0];
                        r_root <= {r_root[srlm_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_sub_a[srlm_pkg::REM_W-1:0];
                        r_root <= {r_root[srlm_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
                // saturate when the quotient would need more than the level width
                srlm_pkg::S_DIV_CHK: begin
                    if (w_ge) begin
                        r_quot <= '1;
                    end else begin
                        r_rem  <= {18'd0, r_root[srlm_pkg::ROOT_W-1:srlm_pkg::LEVEL_W]};
                        r_quot <= r_root[srlm_pkg::LEVEL_W-1:0];
                        r_cnt  <= srlm_pkg::CNT_W'(srlm_pkg::LEVEL_W - 1);
                    end
                end
                // restoring divide: dividend bits leave r_quot as quotient bits enter
                srlm_pkg::S_DIV: begin
                    r_cnt  <= r_cnt - 1'b1;
                    r_quot <= {r_quot[srlm_pkg::LEVEL_W-2:0], w_ge};
                    if (w_ge) begin
                        r_rem <= {17'd0, w_sub_diff[srlm_pkg::K_W-1:0]};
                    end else begin
                        r_rem <= {17'd0, w_sub_a[srlm_pkg::K_W-1:0]};
                    end
                end
                srlm_pkg::S_CH_DONE: begin
                    if (!r_ch) begin
                        r_lvl_l <= r_quot;
                        if (r_stereo) begin
                            r_ch <= 1'b1;
                        end else begin
                            r_lvl_r <= r_quot;
                        end
                    end else begin
                        r_lvl_r <= r_quot;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: hold a level pair until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == srlm_pkg::S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srlm_pkg::S_OUT && w_out_free) begin
            r_out_l <= r_lvl_l;
            r_out_r <= r_lvl_r;
        end
    end

endmodule

// File: dv/stereo_rms_level_meter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for stereo_rms_level_meter: queued sample driver, level checker, watchdog.
module stereo_rms_level_meter_tb;
    import srlm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 20;     // covers a frame-closing sample still in flight
    localparam int DRAIN_CYCLES   = 400;    // covers two full level computations
    localparam int RANDOM_ITEMS   = 480;
    localparam int BURST_ITEMS    = 40;
    localparam int MAX_REPORTS    = 10;
    localparam logic [7:0] CFG_NO_REG = 8'd200;   // index with no register behind it

    typedef struct {
        logic [31:0] word;
        logic        last;
    } sample_t;

    typedef struct {
        logic [LEVEL_W-1:0] lvl_left;
        logic [LEVEL_W-1:0] lvl_right;
    } levels_t;

    // Block ports; every input starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [31:0] i_sample_word = '0;
    logic        i_last        = 1'b0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [16:0] o_level_left;
    logic [16:0] o_level_right;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    stereo_rms_level_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_word (i_sample_word),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_level_left  (o_level_left),
        .o_level_right (o_level_right),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Level predictor: own copy of the registers and the accumulators.
    // ------------------------------------------------------------------
    logic [1:0] cfg_format   = FMT_S16;
    logic [4:0] cfg_channels = 5'd2;
    logic       cfg_swap     = 1'b0;

    longint sum_l, sum_r, sq_l, sq_r;
    int     frames, frame_pos, held_l, held_r;

    sample_t feed_q[$];     // items waiting for the driver
    levels_t level_q[$];    // predicted levels, oldest first

    int errors = 0;

    task automatic meter_clear();
        sum_l     = 0;
        sum_r     = 0;
        sq_l      = 0;
        sq_r      = 0;
        frames    = 0;
        frame_pos = 0;
        held_l    = 0;
        held_r    = 0;
    endtask

    // Zero channels act as one, anything above sixteen as sixteen.
    function automatic int active_channels();
        int cc;
        cc = int'(cfg_channels);
        if (cc == 0)
            cc = 1;
        if (cc > 16)
            cc = 16;
        return cc;
    endfunction

    function automatic int decode_word(logic [31:0] word);
        logic [15:0]        half;
        logic signed [15:0] s16;
        logic signed [23:0] s24;
        int                 value;
        half = cfg_swap ? {word[7:0], word[15:8]} : word[15:0];
        s16  = half;
        s24  = word[31:8];
        case (cfg_format)
            FMT_U8:  value = int'(word[7:0]);
            FMT_S16: value = int'(s16);
            FMT_S32: value = int'(s24);
            default: value = 0;
        endcase
        return value;
    endfunction

    // Largest r with (r * n * fs)^2 <= (n*Q - S*S) << sh, built bit by bit from the top.
    function automatic logic [LEVEL_W-1:0] rms_level(longint total, longint squares, int n,
                                                     logic [30:0] fs, int sh);
        logic [127:0]       n_w, q_w, mag_w, fs_w, t_w, dev_w, span_w;
        logic [LEVEL_W-1:0] r, t;
        int                 b;
        r     = '0;
        n_w   = 128'(n);
        q_w   = 128'(squares);
        fs_w  = 128'(fs);
        mag_w = 128'((total < 0) ? -total : total);
        if (n != 0 && n_w * q_w >= mag_w * mag_w) begin
            dev_w = (n_w * q_w - mag_w * mag_w) << sh;
            for (b = LEVEL_W - 1; b >= 0; b--) begin
                t      = r;
                t[b]   = 1'b1;
                t_w    = 128'(t);
                span_w = t_w * n_w * fs_w;
                if (dev_w >= span_w * span_w)
                    r = t;
            end
        end
        return r;
    endfunction

    task automatic meter_take_sample(logic [31:0] word, logic last);
        int          cc, x, sh;
        logic [30:0] fs;
        levels_t     lv;
        cc = active_channels();
        x  = decode_word(word);
        // hold channels 0 and 1 of the frame being collected
        if (frame_pos == 0)
            held_l = x;
        else if (frame_pos == 1)
            held_r = x;
        // close the frame once the position reaches or passes the count
        if (frame_pos + 1 >= cc) begin
            if (frames < MAX_FRAMES) begin
                sum_l += held_l;
                sq_l  += longint'(held_l) * held_l;
                if (cc > 1) begin
                    sum_r += held_r;
                    sq_r  += longint'(held_r) * held_r;
                end
                frames++;
            end
            frame_pos = 0;
        end else begin
            frame_pos = (frame_pos + 1) & 15;
        end
        if (last) begin
            lv.lvl_left  = '0;
            lv.lvl_right = '0;
            sh = 32;
            case (cfg_format)
                FMT_U8:  fs = FS_U8;
                FMT_S16: fs = FS_S16;
                FMT_S32: begin
                    fs = FS_S32;
                    sh = 48;
                end
                default: fs = '0;
            endcase
            if (fs != 0 && frames != 0) begin
                lv.lvl_left  = rms_level(sum_l, sq_l, frames, fs, sh);
                lv.lvl_right = (cc > 1) ? rms_level(sum_r, sq_r, frames, fs, sh) : lv.lvl_left;
            end
            level_q.push_back(lv);
            meter_clear();
        end
    endtask

    task automatic flag_error(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Sample driver: pop an item, wait its drawn gap, then hold it until taken.
    // ------------------------------------------------------------------
    logic    sample_taken = 1'b0;
    logic    busy         = 1'b0;
    bit      gaps_on      = 1'b1;
    int      gap_left     = 0;
    sample_t pending;

    always @(posedge i_clk) begin
        sample_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            meter_take_sample(i_sample_word, i_last);
    end

    always @(negedge i_clk) begin
        if (sample_taken)
            busy = 1'b0;
        if (!busy && feed_q.size() != 0) begin
            pending  = feed_q.pop_front();
            gap_left = gaps_on ? $urandom_range(0, 16) : 0;
            busy     = 1'b1;
        end
        if (busy && gap_left == 0) begin
            // keep valid high and the payload steady until the item is taken
            i_valid       <= 1'b1;
            i_sample_word <= pending.word;
            i_last        <= pending.last;
        end else begin
            i_valid <= 1'b0;
            if (busy)
                gap_left--;
        end
    end

    // ------------------------------------------------------------------
    // Level monitor: compare each taken item with the oldest prediction.
    // ------------------------------------------------------------------
    logic level_taken = 1'b0;
    logic valid_seen  = 1'b0;
    bit   stalls_on   = 1'b1;
    int   stall_left  = 0;

    always @(posedge i_clk) begin : level_check
        levels_t want;
        level_taken <= i_rst_n && o_valid && !i_stall;
        valid_seen  <= o_valid;
        if (i_rst_n && o_valid && !i_stall) begin
            if (level_q.size() == 0) begin
                flag_error($sformatf("unexpected level item: left %0d right %0d",
                                     o_level_left, o_level_right));
            end else begin
                want = level_q.pop_front();
                if (o_level_left !== want.lvl_left || o_level_right !== want.lvl_right)
                    flag_error($sformatf("level mismatch: expected left %0d right %0d, got left %0d right %0d",
                                         want.lvl_left, want.lvl_right,
                                         o_level_left, o_level_right));
            end
        end
    end

    // Draw a stall per item; count it down only while a level is offered.
    always @(negedge i_clk) begin
        if (level_taken)
            stall_left = stalls_on ? $urandom_range(0, 16) : 0;
        else if (valid_seen && stall_left > 0)
            stall_left--;
        i_stall <= (stall_left > 0);
    end

    // Abort when no channel moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("stereo_rms_level_meter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [7:0] index, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (index)
            CFG_SAMPLE_FORMAT: cfg_format   = data[1:0];
            CFG_CHANNEL_COUNT: cfg_channels = data[4:0];
            CFG_BIG_ENDIAN:    cfg_swap     = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain the queue and the predictions, then let a closing frame finish.
    task automatic wait_idle();
        while (feed_q.size() != 0 || busy || level_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Set junk above the register field now and then.
    function automatic logic [31:0] pad_bits(logic [31:0] value, int width);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        return (junk << width) | value;
    endfunction

    function automatic logic [31:0] edge_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'h0000_7FFF;
            3:       w = 32'h0000_8000;
            4:       w = 32'h7FFF_FFFF;
            5:       w = 32'h8000_0000;
            6:       w = 32'h0000_00FF;
            default: w = 32'h0000_0080;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_word();
        return ($urandom_range(0, 5) == 0) ? edge_word() : $urandom;
    endfunction

    initial begin : stimulus
        int          eff, frames_n, len, n_rand, n_buf, k;
        bit          flat;
        logic [1:0]  fmt;
        logic [4:0]  chans;
        logic [31:0] base;

        meter_clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset settings: 16-bit, stereo, little endian.
        feed_q.push_back('{32'h0000_1234, 1'b1});          // empty buffer
        feed_q.push_back('{32'h0000_7FFF, 1'b0});          // full-scale extremes
        feed_q.push_back('{32'h0000_8000, 1'b0});
        feed_q.push_back('{32'hFFFF_8000, 1'b0});
        feed_q.push_back('{32'h0000_7FFF, 1'b0});
        feed_q.push_back('{32'h0000_0000, 1'b0});
        feed_q.push_back('{32'hFFFF_FFFF, 1'b1});
        feed_q.push_back('{32'h0001_0100, 1'b0});          // partial final frame
        feed_q.push_back('{32'hFFFF_0002, 1'b0});
        feed_q.push_back('{32'h0000_0003, 1'b1});
        feed_q.push_back('{32'h0000_4000, 1'b0});          // leave a frame open
        wait_idle();

        // Switch to 32-bit mono mid-frame: the open frame closes past its count.
        write_reg(CFG_SAMPLE_FORMAT, 32'hFFFF_FFFE);
        write_reg(CFG_CHANNEL_COUNT, 32'd0);
        write_reg(CFG_BIG_ENDIAN, 32'd1);
        feed_q.push_back('{32'h8000_0000, 1'b0});
        feed_q.push_back('{32'h7FFF_FF00, 1'b0});
        feed_q.push_back('{32'h0000_00FF, 1'b0});
        feed_q.push_back('{32'hFFFF_FFFF, 1'b1});
        wait_idle();

        // 8-bit with an oversized count; the buffer never fills a frame.
        write_reg(CFG_SAMPLE_FORMAT, 32'(FMT_U8));
        write_reg(CFG_CHANNEL_COUNT, 32'd31);
        write_reg(CFG_NO_REG, $urandom);
        feed_q.push_back('{32'h0000_00FF, 1'b0});
        feed_q.push_back('{32'h0000_0000, 1'b0});
        feed_q.push_back('{32'h0000_0080, 1'b1});
        wait_idle();

        // Unsupported format gives zero levels.
        write_reg(CFG_SAMPLE_FORMAT, 32'(FMT_NONE));
        write_reg(CFG_CHANNEL_COUNT, 32'd2);
        feed_q.push_back('{32'h1234_5678, 1'b0});
        feed_q.push_back('{32'h9ABC_DEF0, 1'b1});
        wait_idle();

        // Byte-swapped 16-bit extremes.
        write_reg(CFG_SAMPLE_FORMAT, 32'(FMT_S16));
        feed_q.push_back('{32'h0000_0080, 1'b0});
        feed_q.push_back('{32'h0000_FF7F, 1'b1});
        wait_idle();

        // One mono buffer back to back, with neither gaps nor stalls.
        write_reg(CFG_SAMPLE_FORMAT, 32'(FMT_U8));
        write_reg(CFG_CHANNEL_COUNT, 32'd1);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (k = 0; k < BURST_ITEMS; k++)
            feed_q.push_back('{$urandom, k == BURST_ITEMS - 1});
        wait_idle();

        // Random phases: mostly well-formed buffers, some noise, some open tails.
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: fmt = FMT_U8;
                3, 4, 5: fmt = FMT_S16;
                6, 7, 8: fmt = FMT_S32;
                default: fmt = FMT_NONE;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: chans = 5'd2;
                5, 6:          chans = 5'd1;
                7:             chans = 5'd0;
                8:             chans = 5'($urandom_range(3, 16));
                default:       chans = 5'($urandom_range(17, 31));
            endcase
            write_reg(CFG_SAMPLE_FORMAT, pad_bits(32'(fmt), 2));
            write_reg(CFG_CHANNEL_COUNT, pad_bits(32'(chans), 5));
            write_reg(CFG_BIG_ENDIAN, pad_bits($urandom_range(0, 1), 1));
            eff = active_channels();

            for (n_buf = $urandom_range(1, 4); n_buf > 0; n_buf--) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise: random length, random last flags
                    len = $urandom_range(1, 12);
                    for (k = 0; k < len; k++)
                        feed_q.push_back('{pick_word(), $urandom_range(0, 7) == 0});
                end else begin
                    frames_n = (eff > 4) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                    len      = frames_n * eff;
                    if (eff > 1 && $urandom_range(0, 4) == 0)
                        len += $urandom_range(1, eff - 1);
                    // a flat buffer has no spread about its mean
                    flat = ($urandom_range(0, 4) == 0);
                    base = pick_word();
                    for (k = 0; k < len; k++)
                        feed_q.push_back('{flat ? base : pick_word(), k == len - 1});
                end
                n_rand += len;
            end

            // carry an open buffer into the next settings
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, eff);
                for (k = 0; k < len; k++)
                    feed_q.push_back('{pick_word(), 1'b0});
                n_rand += len;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        errors += level_q.size();
        if (errors == 0)
            $display("stereo_rms_level_meter regression: pass");
        else
            $display("stereo_rms_level_meter regression: fail");
        $finish;
    end

endmodule
